// File: design/dir_entry_scan_seq_name_defines.svh
// ----------------------------------------------------------------------------
// dir_entry_scan_seq_name_defines.svh
// Assertion macros for the directory scanner checker.
// ----------------------------------------------------------------------------
`ifndef DIR_ENTRY_SCAN_SEQ_NAME_DEFINES_SVH
`define DIR_ENTRY_SCAN_SEQ_NAME_DEFINES_SVH

// same-cycle implication, disabled in reset
`define DESS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define DESS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/dess_pkg.sv
// ----------------------------------------------------------------------------
// dess_pkg
// Constants for the directory slot scanner with sequential naming.
// ----------------------------------------------------------------------------
package dess_pkg;

    localparam int NAME_W = 64;
    localparam int EXT_W  = 24;
    localparam int SLOT_W = 4;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_BASE_NAME  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_EXT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PREFIX_LEN = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DIGIT_CNT  = 2'd3;

    localparam logic [7:0] SLOT_UNUSED  = 8'h00;
    localparam logic [7:0] SLOT_DELETED = 8'hE5;
    localparam logic [7:0] CHR_0        = 8'h30;
    localparam logic [7:0] CHR_COLON    = 8'h3A;
    localparam logic [7:0] CHR_A        = 8'h41;
    localparam logic [7:0] CHR_F        = 8'h46;

    localparam logic [3:0] NAME_BYTES = 4'd8;
    localparam logic [3:0] EXT_BYTES  = 4'd3;

endpackage

// File: design/dir_entry_scan_seq_name.sv
// ----------------------------------------------------------------------------
// dir_entry_scan_seq_name
// An entry word that yields a result goes via the input and result registers.
// Throughput: one entry word per cycle; the input register drains every cycle
// unless a held result word blocks a new one.
// Reset: configuration, candidate name, entry index and hit flag clear.
// Scans directory entries for a free slot and tracks the next sequence name.
// ----------------------------------------------------------------------------
module dir_entry_scan_seq_name #(
    parameter int ENTRIES_PER_SECTOR = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [dess_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [dess_pkg::NAME_W-1:0]       cfg_data,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [dess_pkg::NAME_W-1:0]       entry_name,
    input  logic [dess_pkg::EXT_W-1:0]        entry_ext,
    input  logic                              new_search,
    input  logic                              last_of_sector,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic                              found,
    output logic [dess_pkg::SLOT_W-1:0]       slot_index,
    output logic [dess_pkg::NAME_W-1:0]       chosen_name
);

    localparam int CNT_W = (ENTRIES_PER_SECTOR > 1) ? $clog2(ENTRIES_PER_SECTOR) : 1;
    localparam logic [CNT_W:0] LAST_IDX = (CNT_W + 1)'(ENTRIES_PER_SECTOR - 1);

    // configuration
    logic [dess_pkg::NAME_W-1:0] base_name_reg;
    logic [dess_pkg::EXT_W-1:0]  base_ext_reg;
    logic [3:0]                  prefix_length_reg;
    logic [3:0]                  digit_count_reg;

    // scan state
    logic [dess_pkg::NAME_W-1:0] cand_reg, cand_next;
    logic [CNT_W-1:0]            cnt_reg, cnt_next;
    logic                        hit_reg, hit_next;

    // input register
    logic                        s1_valid_reg, s1_valid_next;
    logic [dess_pkg::NAME_W-1:0] s1_name_reg;
    logic [dess_pkg::EXT_W-1:0]  s1_ext_reg;
    logic                        s1_fresh_reg;
    logic                        s1_last_reg;

    // result register
    logic                        out_valid_reg, out_valid_next;
    logic                        found_reg;
    logic [dess_pkg::SLOT_W-1:0] slot_reg;
    logic [dess_pkg::NAME_W-1:0] name_reg;

    logic                        in_take;
    logic                        s1_go;
    logic                        out_load;
    logic                        produce;
    logic                        is_free;
    logic                        sec_end;
    logic                        apply;
    logic                        adv;
    logic                        cmp_done;
    logic                        carry;
    logic [dess_pkg::NAME_W-1:0] cand_cur;
    logic [dess_pkg::NAME_W-1:0] named;
    logic [CNT_W-1:0]            idx;
    logic [CNT_W+3:0]            idx_ext;
    logic                        hit_cur;
    logic [3:0]                  lo;
    logic [3:0]                  hi;
    logic [4:0]                  hi_sum;
    logic [7:0]                  eb;
    logic [7:0]                  cb;
    logic [7:0]                  nb;

    function automatic logic bytes_match(
        input logic [dess_pkg::NAME_W-1:0] a,
        input logic [dess_pkg::NAME_W-1:0] b,
        input logic [3:0]                  n
    );
        logic       res;
        logic       done;
        logic [7:0] x;
        logic [7:0] y;
        res  = 1'b1;
        done = 1'b0;
        for (int i = 0; i < 8; i++)
        begin
            x = a[i*8 +: 8];
            y = b[i*8 +: 8];
            if (!done && (4'(i) < n))
            begin
                if (x != y)
                begin
                    res  = 1'b0;
                    done = 1'b1;
                end
                else if (x == 8'h00)
                begin
                    done = 1'b1;
                end
            end
        end
        return res;
    endfunction

    assign cfg_ready = 1'b1;

    // entry evaluation
    always_comb
    begin
        cand_cur = s1_fresh_reg ? base_name_reg : cand_reg;
        idx      = s1_fresh_reg ? '0 : cnt_reg;
        hit_cur  = s1_fresh_reg ? 1'b0 : hit_reg;
        idx_ext  = {4'b0000, idx};
        sec_end  = s1_last_reg || ({1'b0, idx} >= LAST_IDX);
        is_free  = (s1_name_reg[7:0] == dess_pkg::SLOT_UNUSED) ||
                   (s1_name_reg[7:0] == dess_pkg::SLOT_DELETED);

        lo     = (prefix_length_reg > dess_pkg::NAME_BYTES) ? dess_pkg::NAME_BYTES
                                                            : prefix_length_reg;
        hi_sum = {1'b0, lo} + {1'b0, digit_count_reg};
        hi     = (hi_sum > {1'b0, dess_pkg::NAME_BYTES}) ? dess_pkg::NAME_BYTES
                                                          : hi_sum[3:0];

        // digit field: entry must be >= candidate, first byte most significant
        adv      = 1'b1;
        cmp_done = 1'b0;
        for (int i = 0; i < 8; i++)
        begin
            eb = s1_name_reg[i*8 +: 8];
            cb = cand_cur[i*8 +: 8];
            if (!cmp_done && (4'(i) >= lo) && (4'(i) < hi))
            begin
                if (eb < cb)
                begin
                    adv      = 1'b0;
                    cmp_done = 1'b1;
                end
                else if (eb > cb)
                begin
                    cmp_done = 1'b1;
                end
            end
        end

        apply = (digit_count_reg != 4'd0) &&
                bytes_match(s1_name_reg, cand_cur, lo) &&
                bytes_match({40'd0, s1_ext_reg}, {40'd0, base_ext_reg},
                            dess_pkg::EXT_BYTES) &&
                adv;

        // entry digits plus one, 0-9A-F
        named = cand_cur;
        carry = 1'b1;
        for (int i = 7; i >= 0; i--)
        begin
            eb = s1_name_reg[i*8 +: 8];
            nb = eb;
            if ((4'(i) >= lo) && (4'(i) < hi))
            begin
                if (carry)
                begin
                    nb = eb + 8'd1;
                    if (nb == dess_pkg::CHR_COLON)
                    begin
                        nb    = dess_pkg::CHR_A;
                        carry = 1'b0;
                    end
                    else if (nb > dess_pkg::CHR_F)
                    begin
                        nb    = dess_pkg::CHR_0;
                        carry = 1'b1;
                    end
                    else
                    begin
                        carry = 1'b0;
                    end
                end
                named[i*8 +: 8] = nb;
            end
        end

        produce   = !hit_cur && (is_free || sec_end);
        cand_next = (!hit_cur && !is_free && apply) ? named : cand_cur;
        cnt_next  = sec_end ? '0 : idx + 1'b1;
        hit_next  = sec_end ? 1'b0 : (hit_cur || is_free);
    end

    // handshake
    assign s1_go    = s1_valid_reg && (!produce || !out_valid_reg || !out_stall);
    assign in_stall = s1_valid_reg && !s1_go;
    assign in_take  = in_valid && !in_stall;
    assign out_load = s1_go && produce;

    always_comb
    begin
        s1_valid_next  = in_take ? 1'b1 : (s1_go ? 1'b0 : s1_valid_reg);
        out_valid_next = out_load || (out_valid_reg && out_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_name_reg     <= '0;
            base_ext_reg      <= '0;
            prefix_length_reg <= '0;
            digit_count_reg   <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                dess_pkg::CFG_BASE_NAME:  base_name_reg     <= cfg_data;
                dess_pkg::CFG_BASE_EXT:   base_ext_reg      <= cfg_data[dess_pkg::EXT_W-1:0];
                dess_pkg::CFG_PREFIX_LEN: prefix_length_reg <= cfg_data[3:0];
                dess_pkg::CFG_DIGIT_CNT:  digit_count_reg   <= cfg_data[3:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cand_reg      <= '0;
            cnt_reg       <= '0;
            hit_reg       <= 1'b0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (s1_go)
            begin
                cand_reg <= cand_next;
                cnt_reg  <= cnt_next;
                hit_reg  <= hit_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_name_reg  <= entry_name;
            s1_ext_reg   <= entry_ext;
            s1_fresh_reg <= new_search;
            s1_last_reg  <= last_of_sector;
        end
        if (out_load)
        begin
            found_reg <= is_free;
            slot_reg  <= is_free ? idx_ext[3:0] : '0;
            name_reg  <= cand_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign found       = found_reg;
    assign slot_index  = slot_reg;
    assign chosen_name = name_reg;

endmodule

// File: design/dess_checker.sv
// ----------------------------------------------------------------------------
// dess_checker
// Port-level checks on the directory slot scanner.
// ----------------------------------------------------------------------------
`include "dir_entry_scan_seq_name_defines.svh"

module dess_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_stall,
    input logic                          out_valid,
    input logic                          out_stall,
    input logic                          found,
    input logic [dess_pkg::SLOT_W-1:0]   slot_index,
    input logic [dess_pkg::NAME_W-1:0]   chosen_name
);

    logic held;

    assign held = out_valid && out_stall;

    `DESS_ASSERT_NEXT(a_hold, held, out_valid, "result word dropped while stalled")
    `DESS_ASSERT_NEXT(a_stable, held, $stable({found, slot_index, chosen_name}), "word changed")
    `DESS_ASSERT_NOW(a_stall_cause, in_stall, held, "input stalled with no held word")
    `DESS_ASSERT_NOW(a_miss_slot, out_valid && !found, slot_index == '0, "miss with slot index")

endmodule

bind dir_entry_scan_seq_name dess_checker u_dess_checker (.*);

// File: tb/dir_entry_scan_seq_name_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dir_entry_scan_seq_name_tb
// Streams directory entries, sector by sector, through the slot scanner under
// several register settings, with random gaps on both sides and one long
// output hold-off. A local scan model predicts each result word (free slot or
// not found, with the sequence name) and every result is checked in order.
// ----------------------------------------------------------------------------
module dir_entry_scan_seq_name_tb;

    localparam int ENTRIES      = 16;
    localparam int PHASE_ITEMS  = 105;
    localparam int LONG_HOLD    = 150;
    localparam int DRAIN_CYCLES = 8;
    localparam int STUCK_LIMIT  = 2000;

    typedef struct {
        logic [dess_pkg::NAME_W-1:0] name;
        logic [dess_pkg::EXT_W-1:0]  ext;
        logic                        fresh;
        logic                        last;
    } dir_entry_t;

    typedef struct {
        logic                        found;
        logic [dess_pkg::SLOT_W-1:0] slot;
        logic [dess_pkg::NAME_W-1:0] name;
    } slot_word_t;

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           cfg_valid = 1'b0;
    logic                           cfg_ready;
    logic [dess_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [dess_pkg::NAME_W-1:0]    cfg_data = '0;
    logic                           in_valid = 1'b0;
    logic                           in_stall;
    logic [dess_pkg::NAME_W-1:0]    entry_name = '0;
    logic [dess_pkg::EXT_W-1:0]     entry_ext = '0;
    logic                           new_search = 1'b0;
    logic                           last_of_sector = 1'b0;
    logic                           out_valid;
    logic                           out_stall = 1'b0;
    logic                           found;
    logic [dess_pkg::SLOT_W-1:0]    slot_index;
    logic [dess_pkg::NAME_W-1:0]    chosen_name;

    dir_entry_scan_seq_name #(.ENTRIES_PER_SECTOR(ENTRIES)) uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .entry_name     (entry_name),
        .entry_ext      (entry_ext),
        .new_search     (new_search),
        .last_of_sector (last_of_sector),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .found          (found),
        .slot_index     (slot_index),
        .chosen_name    (chosen_name)
    );

    // register copies and scan state of the local model
    logic [dess_pkg::NAME_W-1:0] reg_base_name = '0;
    logic [dess_pkg::EXT_W-1:0]  reg_base_ext = '0;
    logic [3:0]                  reg_prefix_len = '0;
    logic [3:0]                  reg_digit_cnt = '0;
    logic [dess_pkg::NAME_W-1:0] cand_name = '0;
    int unsigned                 scan_idx = 0;
    bit                          sector_hit = 1'b0;

    dir_entry_t  entries_waiting[$];
    slot_word_t  slots_due[$];
    dir_entry_t  next_entry;
    int unsigned send_gap = 0;
    int unsigned stall_left = 0;
    int unsigned calm_left = 0;
    int unsigned hold_reqs = 0;
    int unsigned holds_served = 0;
    bit          no_gaps = 1'b0;
    int unsigned mismatches = 0;
    int unsigned stuck_cycles = 0;

    initial
    begin
        forever #1 clk = ~clk;
    end

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (no_gaps || r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic bit bytes_agree(logic [dess_pkg::NAME_W-1:0] a,
                                       logic [dess_pkg::NAME_W-1:0] b,
                                       int unsigned n);
        int unsigned i;
        for (i = 0; i < n; i++)
        begin
            if (a[i*8 +: 8] != b[i*8 +: 8])
                return 1'b0;
            if (a[i*8 +: 8] == 8'h00)
                return 1'b1;
        end
        return 1'b1;
    endfunction

    function automatic void advance_name(logic [dess_pkg::NAME_W-1:0] name,
                                         logic [dess_pkg::EXT_W-1:0] ext);
        int unsigned lo;
        int unsigned hi;
        int unsigned i;
        logic [7:0]  e;
        logic [7:0]  c;
        logic [7:0]  nb;
        bit          go;
        bit          carry;
        if (reg_digit_cnt == 0)
            return;
        lo = (reg_prefix_len > 8) ? 8 : reg_prefix_len;
        hi = lo + reg_digit_cnt;
        if (hi > 8)
            hi = 8;
        if (!bytes_agree(name, cand_name, lo))
            return;
        if (!bytes_agree({40'b0, ext}, {40'b0, reg_base_ext}, dess_pkg::EXT_BYTES))
            return;
        go = 1'b1;
        for (i = lo; i < hi; i++)
        begin
            e = name[i*8 +: 8];
            c = cand_name[i*8 +: 8];
            if (e < c)
            begin
                go = 1'b0;
                break;
            end
            if (e > c)
                break;
        end
        if (!go)
            return;
        carry = 1'b1;
        for (i = hi; i > lo; i--)
        begin
            e = name[(i-1)*8 +: 8];
            if (carry)
            begin
                nb = e + 8'd1;
                if (nb == dess_pkg::CHR_COLON)
                begin
                    nb = dess_pkg::CHR_A;
                    carry = 1'b0;
                end
                else if (nb > dess_pkg::CHR_F)
                begin
                    nb = dess_pkg::CHR_0;
                    carry = 1'b1;
                end
                else
                    carry = 1'b0;
            end
            else
                nb = e;
            cand_name[(i-1)*8 +: 8] = nb;
        end
    endfunction

    function automatic void scan_entry(logic [dess_pkg::NAME_W-1:0] name,
                                       logic [dess_pkg::EXT_W-1:0] ext,
                                       logic fresh, logic last);
        int unsigned idx;
        bit          sector_end;
        slot_word_t  w;
        if (fresh)
        begin
            cand_name = reg_base_name;
            scan_idx = 0;
            sector_hit = 1'b0;
        end
        idx = scan_idx;
        sector_end = last || idx >= ENTRIES - 1;
        if (!sector_hit)
        begin
            if (name[7:0] == dess_pkg::SLOT_UNUSED || name[7:0] == dess_pkg::SLOT_DELETED)
            begin
                w.found = 1'b1;
                w.slot = 4'(idx);
                w.name = cand_name;
                slots_due.push_back(w);
                sector_hit = 1'b1;
            end
            else
            begin
                advance_name(name, ext);
                if (sector_end)
                begin
                    w.found = 1'b0;
                    w.slot = '0;
                    w.name = cand_name;
                    slots_due.push_back(w);
                end
            end
        end
        if (sector_end)
        begin
            scan_idx = 0;
            sector_hit = 1'b0;
        end
        else
            scan_idx = idx + 1;
    endfunction

    function automatic logic [dess_pkg::NAME_W-1:0] pack_name(input string s);
        logic [dess_pkg::NAME_W-1:0] v;
        int                          i;
        v = '0;
        for (i = 0; i < s.len() && i < 8; i++)
            v[i*8 +: 8] = s[i];
        return v;
    endfunction

    function automatic void queue_entry(logic [dess_pkg::NAME_W-1:0] name,
                                        logic [dess_pkg::EXT_W-1:0] ext,
                                        logic fresh, logic last);
        dir_entry_t d;
        d.name = name;
        d.ext = ext;
        d.fresh = fresh;
        d.last = last;
        entries_waiting.push_back(d);
    endfunction

    // sequence digit, mostly hex characters, sometimes odd bytes
    function automatic logic [7:0] seq_digit();
        int unsigned r;
        r = $urandom_range(0, 19);
        if (r < 10)
            return dess_pkg::CHR_0 + 8'(r);
        if (r < 16)
            return dess_pkg::CHR_A + 8'(r - 10);
        case (r)
            16: return dess_pkg::CHR_COLON;
            17: return 8'hFF;
            18: return dess_pkg::CHR_F + 8'd1;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic logic [dess_pkg::NAME_W-1:0] make_base(int unsigned plen,
                                                              int unsigned dcnt);
        logic [dess_pkg::NAME_W-1:0] v;
        int unsigned                 i;
        v = {$urandom, $urandom};
        for (i = 0; i < 8; i++)
        begin
            if (i < plen)
                v[i*8 +: 8] = dess_pkg::CHR_A + 8'($urandom_range(0, 25));
            else if (i < plen + dcnt)
                v[i*8 +: 8] = ($urandom_range(0, 1) != 0) ? dess_pkg::CHR_0 : seq_digit();
        end
        return v;
    endfunction

    // in-use entry that follows the configured prefix and, mostly, the extension
    function automatic dir_entry_t make_match();
        dir_entry_t  d;
        int unsigned lo;
        int unsigned hi;
        int unsigned i;
        bit          stopped;
        d.name = {$urandom, $urandom};
        d.ext = 24'($urandom);
        d.fresh = 1'b0;
        d.last = 1'b0;
        lo = (reg_prefix_len > 8) ? 8 : reg_prefix_len;
        hi = lo + reg_digit_cnt;
        if (hi > 8)
            hi = 8;
        stopped = 1'b0;
        for (i = 0; i < lo; i++)
        begin
            if (!stopped)
                d.name[i*8 +: 8] = reg_base_name[i*8 +: 8];
            if (reg_base_name[i*8 +: 8] == 8'h00)
                stopped = 1'b1;
        end
        for (i = lo; i < hi; i++)
            d.name[i*8 +: 8] = ($urandom_range(0, 4) == 0) ? reg_base_name[i*8 +: 8]
                                                           : seq_digit();
        stopped = 1'b0;
        if ($urandom_range(0, 7) != 0)
        begin
            for (i = 0; i < dess_pkg::EXT_BYTES; i++)
            begin
                if (!stopped)
                    d.ext[i*8 +: 8] = reg_base_ext[i*8 +: 8];
                if (reg_base_ext[i*8 +: 8] == 8'h00)
                    stopped = 1'b1;
            end
        end
        if (d.name[7:0] == dess_pkg::SLOT_UNUSED || d.name[7:0] == dess_pkg::SLOT_DELETED)
            d.name[7:0] = dess_pkg::CHR_A;
        return d;
    endfunction

    // one sector; returns the number of entry words queued
    function automatic int unsigned queue_sector();
        int unsigned len;
        int unsigned free_at;
        int unsigned k;
        bit          fresh;
        bit          has_free;
        dir_entry_t  d;
        len = ($urandom_range(0, 5) == 0) ? ENTRIES : $urandom_range(1, ENTRIES);
        fresh = $urandom_range(0, 4) != 0;
        has_free = $urandom_range(0, 9) < 6;
        free_at = $urandom_range(0, len - 1);
        for (k = 0; k < len; k++)
        begin
            if (has_free && k == free_at)
            begin
                d.name = {$urandom, $urandom};
                d.name[7:0] = ($urandom_range(0, 1) != 0) ? dess_pkg::SLOT_UNUSED
                                                          : dess_pkg::SLOT_DELETED;
                d.ext = 24'($urandom);
            end
            else if ($urandom_range(0, 9) < 7)
                d = make_match();
            else
            begin
                d.name = {$urandom, $urandom};
                d.name[7:0] = 8'($urandom_range(1, 8'hE4));
                d.ext = 24'($urandom);
            end
            queue_entry(d.name, d.ext, fresh && k == 0,
                        k == len - 1 && (len < ENTRIES || $urandom_range(0, 1) != 0));
        end
        return len;
    endfunction

    task automatic write_reg(input logic [dess_pkg::CFG_IDX_W-1:0] idx,
                             input logic [dess_pkg::NAME_W-1:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            dess_pkg::CFG_BASE_NAME:  reg_base_name = val;
            dess_pkg::CFG_BASE_EXT:   reg_base_ext = val[dess_pkg::EXT_W-1:0];
            dess_pkg::CFG_PREFIX_LEN: reg_prefix_len = val[3:0];
            dess_pkg::CFG_DIGIT_CNT:  reg_digit_cnt = val[3:0];
            default: ;
        endcase
    endtask

    task automatic write_setting(input logic [dess_pkg::NAME_W-1:0] bname,
                                 input logic [dess_pkg::EXT_W-1:0] bext,
                                 input int unsigned plen, input int unsigned dcnt);
        write_reg(dess_pkg::CFG_BASE_NAME, bname);
        write_reg(dess_pkg::CFG_BASE_EXT, {40'b0, bext});
        write_reg(dess_pkg::CFG_PREFIX_LEN, dess_pkg::NAME_W'(plen));
        write_reg(dess_pkg::CFG_DIGIT_CNT, dess_pkg::NAME_W'(dcnt));
    endtask

    // wait until every queued word is accepted and every result word is back
    task automatic settle();
        while (entries_waiting.size() != 0 || in_valid || slots_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // entry word driver
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                scan_entry(entry_name, entry_ext, new_search, last_of_sector);
            if (!(in_valid && in_stall))
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    in_valid <= 1'b0;
                end
                else if (entries_waiting.size() > 0)
                begin
                    next_entry = entries_waiting.pop_front();
                    entry_name <= next_entry.name;
                    entry_ext <= next_entry.ext;
                    new_search <= next_entry.fresh;
                    last_of_sector <= next_entry.last;
                    in_valid <= 1'b1;
                    send_gap = pick_gap();
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // result side stall pattern
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (holds_served != hold_reqs)
            begin
                holds_served = hold_reqs;
                stall_left = LONG_HOLD;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= 1'b0;
                if (calm_left > 0)
                    calm_left--;
                else
                begin
                    stall_left = pick_gap();
                    calm_left = $urandom_range(0, 24);
                end
            end
        end
    end

    // result word checker
    always @(posedge clk)
    begin
        slot_word_t w;
        if (rst_n && out_valid && !out_stall)
        begin
            if (slots_due.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result word: found %0d slot %0d name %h",
                             found, slot_index, chosen_name);
            end
            else
            begin
                w = slots_due.pop_front();
                if (found !== w.found || slot_index !== w.slot || chosen_name !== w.name)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: found %0d/%0d slot %0d/%0d name %h/%h",
                                 w.found, found, w.slot, slot_index, w.name, chosen_name);
                end
            end
        end
    end

    initial
    begin
        while (stuck_cycles < STUCK_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
                (cfg_valid && cfg_ready))
                stuck_cycles = 0;
            else
                stuck_cycles++;
        end
        $display("watchdog: no handshake for %0d cycles", STUCK_LIMIT);
        $display("dir_entry_scan_seq_name verification failed");
        $finish;
    end

    initial
    begin
        logic [dess_pkg::NAME_W-1:0] bname;
        logic [dess_pkg::NAME_W-1:0] odd_name;
        logic [dess_pkg::EXT_W-1:0]  bext;
        logic [dess_pkg::EXT_W-1:0]  txt;
        int unsigned                 ph;
        int unsigned                 live;
        int unsigned                 plen;
        int unsigned                 dcnt;
        bit                          paused;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // directed: free slots, naming steps, odd digits, not found
        txt = dess_pkg::EXT_W'(pack_name("TXT"));
        write_setting(pack_name("FILE0000"), txt, 4, 4);
        queue_entry('0, '0, 1'b1, 1'b0);
        queue_entry(pack_name("FILE0005"), txt, 1'b1, 1'b0);
        queue_entry(pack_name("FILE0003"), txt, 1'b0, 1'b0);
        queue_entry(pack_name("FILE0006"), txt, 1'b0, 1'b0);
        queue_entry(pack_name("FILE0009"), txt, 1'b0, 1'b0);
        queue_entry(pack_name("FILE00FF"), txt, 1'b0, 1'b0);
        queue_entry(pack_name("FILE0100"), dess_pkg::EXT_W'(pack_name("TXU")), 1'b0, 1'b0);
        queue_entry(pack_name("FILX0200"), txt, 1'b0, 1'b0);
        queue_entry(pack_name("FILE010:"), txt, 1'b0, 1'b0);
        odd_name = pack_name("FILEFFFF");
        odd_name[39:32] = 8'hFF;
        queue_entry(odd_name, txt, 1'b0, 1'b0);
        queue_entry('1, '1, 1'b0, 1'b1);
        queue_entry(pack_name("FILE0000"), txt, 1'b0, 1'b0);
        odd_name = pack_name("NEWFILE");
        odd_name[7:0] = dess_pkg::SLOT_DELETED;
        queue_entry(odd_name, txt, 1'b0, 1'b0);
        queue_entry(pack_name("FILE9999"), txt, 1'b0, 1'b0);
        queue_entry(pack_name("FILE9999"), txt, 1'b0, 1'b1);
        queue_entry(odd_name, '1, 1'b1, 1'b1);
        settle();

        for (ph = 0; ph < 10; ph++)
        begin
            case (ph)
                0:
                begin
                    plen = 0;
                    dcnt = 8;
                end
                1:
                begin
                    plen = 8;
                    dcnt = 8;
                end
                2:
                begin
                    plen = 15;
                    dcnt = 3;
                end
                3:
                begin
                    plen = 6;
                    dcnt = 8;
                end
                4:
                begin
                    plen = 0;
                    dcnt = 0;
                end
                5:
                begin
                    plen = 4;
                    dcnt = 4;
                end
                9:
                begin
                    plen = 1;
                    dcnt = 1;
                end
                default:
                begin
                    plen = $urandom_range(0, 8);
                    dcnt = $urandom_range(1, 8);
                end
            endcase
            bname = make_base(plen, dcnt);
            bext = {dess_pkg::CHR_A + 8'($urandom_range(0, 25)),
                    dess_pkg::CHR_A + 8'($urandom_range(0, 25)),
                    dess_pkg::CHR_A + 8'($urandom_range(0, 25))};
            if (ph == 4)
            begin
                bname = '1;
                bext = '1;
            end
            if (ph == 5)
            begin
                // zero bytes end the prefix and extension compares early
                bname[23:16] = 8'h00;
                bext[15:8] = 8'h00;
            end
            if (ph == 7)
                bext = 24'($urandom);
            write_setting(bname, bext, plen, dcnt);
            no_gaps = (ph == 8);
            if (ph == 6)
                hold_reqs++;
            paused = 1'b0;
            live = 0;
            while (live < PHASE_ITEMS)
            begin
                if (ph == 7 && !paused && live >= PHASE_ITEMS / 2)
                begin
                    paused = 1'b1;
                    settle();
                end
                if ($urandom_range(0, 9) == 0)
                begin
                    queue_entry({$urandom, $urandom}, 24'($urandom),
                                $urandom_range(0, 3) == 0, $urandom_range(0, 1) != 0);
                    live++;
                end
                else
                    live += queue_sector();
            end
            settle();
            no_gaps = 1'b0;
        end

        if (slots_due.size() != 0)
        begin
            mismatches += slots_due.size();
            $display("%0d result words never arrived", slots_due.size());
        end
        if (mismatches == 0)
            $display("dir_entry_scan_seq_name verification clean");
        else
            $display("dir_entry_scan_seq_name verification failed");
        $finish;
    end

endmodule

// File: dir_entry_scan_seq_name.f
+incdir+design
design/dess_pkg.sv
design/dir_entry_scan_seq_name.sv
design/dess_checker.sv
tb/dir_entry_scan_seq_name_tb.sv
